// ===== rtl/mbe_pkg.sv =====
// Shared types, widths and helpers for the Mandelbrot escape-time core.
// No dependencies; every other RTL file except mbe_checker imports this package.
package mbe_pkg;

  // Countdown start value and output clip
  localparam int MAX_ITER    = 256;
  localparam int REM_W       = $clog2(MAX_ITER + 1);
  localparam int OUT_W       = 8;
  localparam int OUT_MAX     = 255;

  // Field and datapath widths
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 28;
  localparam int IDX_W       = 24;
  localparam int DIM_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_C_W    = DIM_W + COORD_W;
  localparam int PROD_R_W    = IDX_W + COORD_W;
  localparam int DIV_W       = PROD_R_W;
  localparam int STEP_W      = $clog2(DIV_W + 1);
  localparam int WIDE_W      = 66;
  localparam int MUL_W       = 2 * COORD_W;

  // Escape radius squared, as an integer part
  localparam int ESC_LIMIT   = 4;

  // Depth of the queue between front and back
  localparam int QDEPTH      = 2;

  typedef struct packed {
    logic [COORD_W-1:0] left_edge;
    logic [COORD_W-1:0] right_edge;
    logic [COORD_W-1:0] top_edge;
    logic [COORD_W-1:0] bottom_edge;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
  } cfg_t;

  typedef struct packed {
    logic              go;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DIM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIM_W-1:0] rmd;
  } div_resp_t;

  typedef struct packed {
    logic [COORD_W-1:0] c_re;
    logic [COORD_W-1:0] c_im;
  } point_t;

  // Clamp a wide signed value to the 32-bit Q4.28 range
  function automatic logic [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (&v[WIDE_W-1:COORD_W-1]) || (~|v[WIDE_W-1:COORD_W-1]);
    if (fits) begin
      return v[COORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/mandelbrot_escape_time_core.sv =====
// The front makes three divider passes in turn (24, 45 and 56 quotient bits); the back then
// runs k |z|^2 tests (k from 2 to MAX_ITER), each a multiply state then an evaluate state.
// The single shared restoring divider paces the front and the multiply/update loop paces the
// back; the queue lets the front map the next pixel while the back iterates the current one.
// Results are one-cycle strobes on out_valid; the receiver cannot stall them.
// Reset (rst_n low, synchronous): config returns to defaults, queue empties, both sides idle.
//
// Top level of the Mandelbrot escape-time core: config registers, front, divider, queue, back.
// Depends on mbe_pkg, mbe_div, mbe_front, mbe_queue and mbe_back.
module mandelbrot_escape_time_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Pixel command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [mbe_pkg::IDX_W-1:0]     in_pixel_index,
  // Result strobe
  output logic                          out_valid,
  output logic [mbe_pkg::OUT_W-1:0]     out_iterations_left,
  // Config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbe_pkg::COORD_W-1:0]   cfg_data
);
  import mbe_pkg::*;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(5);

  // Defaults: view from -2.0 to 1.0 across, 1.0 down to -1.0, 640 x 480 pixels
  localparam cfg_t CFG_RESET = '{
    left_edge:    32'hE000_0000,
    right_edge:   32'h1000_0000,
    top_edge:     32'h1000_0000,
    bottom_edge:  32'hF000_0000,
    image_width:  13'd640,
    image_height: 13'd480
  };

  cfg_t      cfg_r;
  div_req_t  div_req;
  div_resp_t div_resp;
  logic      q_full;
  logic      q_push;
  point_t    q_wdata;
  logic      q_pop;
  point_t    q_rdata;
  logic      q_empty;

  // Config writes must land only while idle, as the datapath reads them live; the block does not enforce it.
  // Unknown indexes drop the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT:   cfg_r.left_edge    <= cfg_data;
        REG_RIGHT:  cfg_r.right_edge   <= cfg_data;
        REG_TOP:    cfg_r.top_edge     <= cfg_data;
        REG_BOTTOM: cfg_r.bottom_edge  <= cfg_data;
        REG_WIDTH:  cfg_r.image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: cfg_r.image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept the command, split row/column, map to c, hand c to the queue.
  // busy stays high from the accept until the push of c to the queue is issued.
  mbe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .start       (start),
    .busy        (busy),
    .pixel_index (in_pixel_index),
    .div_req     (div_req),
    .div_resp    (div_resp),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // One divider serves all three front divisions in turn
  mbe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .resp  (div_resp)
  );

  // Decouple: the front maps the next pixel while the back iterates this one
  mbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back: run the escape loop and strobe the remaining count for one cycle
  mbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_iter  (out_iterations_left)
  );

endmodule

// ===== rtl/mbe_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, shared by the front.
// Depends on mbe_pkg (div_req_t, div_resp_t, widths).
module mbe_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mbe_pkg::div_req_t  req,
  output mbe_pkg::div_resp_t resp
);
  import mbe_pkg::*;

  logic [DIV_W-1:0]  dq_r;
  logic [DIM_W-1:0]  rmd_r;
  logic [DIM_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIM_W:0]    trial;
  logic              fits;

  // Dividend arrives left-aligned; shift its top bit into the partial remainder
  assign trial = {rmd_r, dq_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      dq_r  <= req.dividend;
      rmd_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DIV_W-2:0], fits};
      rmd_r <= fits ? DIM_W'(trial - {1'b0, dsr_r}) : trial[DIM_W-1:0];
    end
  end

  assign resp.done = done_r;
  assign resp.quot = dq_r;
  assign resp.rmd  = rmd_r;

endmodule

// ===== rtl/mbe_front.sv =====
// Front end: splits the pixel index, maps it onto the plane and queues c.
// Depends on mbe_pkg; drives the shared mbe_div divider.
module mbe_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mbe_pkg::cfg_t             cfg,
  input  logic                      start,
  output logic                      busy,
  input  logic [mbe_pkg::IDX_W-1:0] pixel_index,
  output mbe_pkg::div_req_t         div_req,
  input  mbe_pkg::div_resp_t        div_resp,
  input  logic                      q_full,
  output logic                      q_push,
  output mbe_pkg::point_t           q_data
);
  import mbe_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_SPLIT, F_DIV_RE, F_DIV_IM, F_PUSH} fstate_t;

  fstate_t               state_r;
  div_req_t              req_r;
  logic                  push_r;
  point_t                pt_r;
  logic [PROD_R_W-1:0]   prod_im_r;

  logic [DIM_W-1:0]         wdt;
  logic [DIM_W-1:0]         hgt;
  logic signed [COORD_W:0]  dr;
  logic signed [COORD_W:0]  di;
  logic [COORD_W-1:0]       mag_re;
  logic [COORD_W-1:0]       mag_im;
  logic [PROD_C_W-1:0]      prod_re;
  logic [PROD_R_W-1:0]      prod_im;
  logic signed [WIDE_W-1:0] qw;
  logic signed [WIDE_W-1:0] sum_re;
  logic signed [WIDE_W-1:0] sum_im;

  always_comb begin
    wdt    = (cfg.image_width == '0) ? DIM_W'(1) : cfg.image_width;
    hgt    = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
    dr     = (COORD_W+1)'($signed(cfg.right_edge)) - (COORD_W+1)'($signed(cfg.left_edge));
    di     = (COORD_W+1)'($signed(cfg.top_edge)) - (COORD_W+1)'($signed(cfg.bottom_edge));
    mag_re = dr[COORD_W] ? COORD_W'(-dr) : dr[COORD_W-1:0];
    mag_im = di[COORD_W] ? COORD_W'(-di) : di[COORD_W-1:0];
    // col and row come straight off the divider after the split pass
    prod_re = PROD_C_W'(div_resp.rmd) * PROD_C_W'(mag_re);
    prod_im = PROD_R_W'(div_resp.quot[IDX_W-1:0]) * PROD_R_W'(mag_im);
    // Quotient of magnitudes; the sign of the span restores truncation toward zero
    qw     = $signed({{(WIDE_W-DIV_W){1'b0}}, div_resp.quot});
    sum_re = WIDE_W'($signed(cfg.left_edge)) + (dr[COORD_W] ? -qw : qw);
    sum_im = WIDE_W'($signed(cfg.top_edge)) - (di[COORD_W] ? -qw : qw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      req_r.go <= 1'b0;
      push_r   <= 1'b0;
    end else begin
      req_r.go <= 1'b0;
      push_r   <= 1'b0;
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            req_r.go       <= 1'b1;
            req_r.steps    <= STEP_W'(IDX_W);
            req_r.dividend <= {pixel_index, {(DIV_W-IDX_W){1'b0}}};
            req_r.divisor  <= wdt;
            state_r        <= F_SPLIT;
          end
        end
        F_SPLIT: begin
          if (div_resp.done) begin
            req_r.go       <= 1'b1;
            req_r.steps    <= STEP_W'(PROD_C_W);
            req_r.dividend <= {prod_re, {(DIV_W-PROD_C_W){1'b0}}};
            req_r.divisor  <= wdt;
            prod_im_r      <= prod_im;
            state_r        <= F_DIV_RE;
          end
        end
        F_DIV_RE: begin
          if (div_resp.done) begin
            pt_r.c_re      <= sat32(sum_re);
            req_r.go       <= 1'b1;
            req_r.steps    <= STEP_W'(PROD_R_W);
            req_r.dividend <= prod_im_r;
            req_r.divisor  <= hgt;
            state_r        <= F_DIV_IM;
          end
        end
        F_DIV_IM: begin
          if (div_resp.done) begin
            pt_r.c_im <= sat32(sum_im);
            state_r   <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            push_r  <= 1'b1;
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign busy    = (state_r != F_IDLE);
  assign div_req = req_r;
  assign q_push  = push_r;
  assign q_data  = pt_r;

endmodule

// ===== rtl/mbe_queue.sv =====
// Small FIFO of mapped points between the front and the back.
// Depends on mbe_pkg (point_t, QDEPTH).
module mbe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbe_pkg::point_t push_data,
  output logic            full,
  input  logic            pop,
  output mbe_pkg::point_t pop_data,
  output logic            empty
);
  import mbe_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  point_t           mem_r [QDEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(QDEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(QDEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mbe_back.sv =====
// Back end: iterates z = z^2 + c for one queued point and strobes the count.
// Depends on mbe_pkg (point_t, sat32, widths).
module mbe_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  mbe_pkg::point_t           q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  output logic [mbe_pkg::OUT_W-1:0] out_iter
);
  import mbe_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_EVAL} bstate_t;

  localparam logic [MUL_W:0] LIMIT = (MUL_W+1)'(ESC_LIMIT) << (2 * FRAC_W);

  bstate_t                   state_r;
  logic signed [COORD_W-1:0] cr_r;
  logic signed [COORD_W-1:0] ci_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic signed [MUL_W-1:0]   xx_r;
  logic signed [MUL_W-1:0]   yy_r;
  logic signed [MUL_W-1:0]   xy_r;
  logic [REM_W-1:0]          rem_r;
  logic                      out_valid_r;
  logic [OUT_W-1:0]          out_iter_r;

  logic [MUL_W:0]            mag;
  logic                      escape;
  logic [REM_W-1:0]          rem_dec;
  logic signed [WIDE_W-1:0]  re_sum;
  logic signed [WIDE_W-1:0]  im_sum;
  logic signed [WIDE_W-1:0]  re_shr;
  logic signed [WIDE_W-1:0]  im_shr;
  logic [COORD_W-1:0]        nx;
  logic [COORD_W-1:0]        ny;
  logic [OUT_W-1:0]          rem_clip;

  always_comb begin
    q_pop   = (state_r == B_IDLE) && !q_empty;
    // Squares are non-negative, so the magnitude is an exact unsigned sum
    mag     = {1'b0, xx_r} + {1'b0, yy_r};
    escape  = mag > LIMIT;
    rem_dec = rem_r - REM_W'(1);
    // Fold c in before the floor shift: floor(a/2^k) + c == floor((a + c*2^k)/2^k)
    re_sum  = WIDE_W'(xx_r) - WIDE_W'(yy_r) + (WIDE_W'(cr_r) <<< FRAC_W);
    im_sum  = WIDE_W'(xy_r) + (WIDE_W'(ci_r) <<< (FRAC_W - 1));
    re_shr  = re_sum >>> FRAC_W;
    im_shr  = im_sum >>> (FRAC_W - 1);
    nx      = sat32(re_shr);
    ny      = sat32(im_shr);
    rem_clip = (32'(rem_r) > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(rem_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            cr_r    <= $signed(q_data.c_re);
            ci_r    <= $signed(q_data.c_im);
            x_r     <= '0;
            y_r     <= '0;
            rem_r   <= REM_W'(MAX_ITER);
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          xx_r    <= x_r * x_r;
          yy_r    <= y_r * y_r;
          xy_r    <= x_r * y_r;
          state_r <= B_EVAL;
        end
        B_EVAL: begin
          if (escape) begin
            out_valid_r <= 1'b1;
            out_iter_r  <= rem_clip;
            state_r     <= B_IDLE;
          end else if (rem_dec == '0) begin
            out_valid_r <= 1'b1;
            out_iter_r  <= '0;
            state_r     <= B_IDLE;
          end else begin
            x_r     <= $signed(nx);
            y_r     <= $signed(ny);
            rem_r   <= rem_dec;
            state_r <= B_MUL;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_iter  = out_iter_r;

endmodule

// ===== rtl/mbe_checker.sv =====
// Port-level checks on the Mandelbrot escape-time core, bound to the top level.
// Depends on mandelbrot_escape_time_core's port names only.
module mbe_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  // An accepted command keeps the front busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a command transfer");

  // The back needs a pop and an iteration between results
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("core not idle after reset");

  // Config writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind mandelbrot_escape_time_core mbe_checker u_mbe_checker (.*);
